### src/mqtx_pkg.sv
// Shared types, constants and helper functions for the multi-queue transmit buffer.
package mqtx_pkg;

    localparam int NUM_TYPES    = 4;
    localparam int NUM_SUBTYPES = 4;
    localparam int SLOTS        = 64;
    localparam int MSG_BITS     = 64;

    localparam int NQ  = NUM_TYPES * NUM_SUBTYPES;
    localparam int QW  = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int IW  = $clog2(SLOTS);
    localparam int SZW = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(NQ * SLOTS);

    localparam int RESET_RING_SIZE = (SLOTS < 10) ? SLOTS : 10;

    localparam logic [2:0] ACT_ENQUEUE = 3'd0;
    localparam logic [2:0] ACT_DEQUEUE = 3'd1;
    localparam logic [2:0] ACT_PEEK    = 3'd2;
    localparam logic [2:0] ACT_FIND    = 3'd3;
    localparam logic [2:0] ACT_ADVANCE = 3'd4;
    localparam logic [2:0] ACT_COUNT   = 3'd5;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  queue_type;
        logic [1:0]  queue_subtype;
        logic [63:0] message_in;
    } mqtx_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  found_type;
        logic [1:0]  found_subtype;
        logic [63:0] message_out;
        logic [5:0]  held_count;
    } mqtx_out_t;

    // Split a queue number into type and subtype by compare against each row start.
    function automatic logic [1:0] queue_type_of(input logic [QW-1:0] q);
        logic [1:0] t;
        t = '0;
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (32'(q) >= 32'(i * NUM_SUBTYPES)) begin
                t = 2'(i);
            end
        end
        return t;
    endfunction

    function automatic logic [1:0] queue_subtype_of(input logic [QW-1:0] q);
        logic [1:0] s;
        s = '0;
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (32'(q) >= 32'(i * NUM_SUBTYPES)) begin
                s = 2'(32'(q) - 32'(i * NUM_SUBTYPES));
            end
        end
        return s;
    endfunction

    // Clamp a written ring size into the range the store supports.
    function automatic logic [SZW-1:0] clamp_ring_size(input logic [6:0] v);
        logic [SZW-1:0] r;
        if (v < 7'd2) begin
            r = SZW'(2);
        end else if (32'(v) > 32'(SLOTS)) begin
            r = SZW'(SLOTS);
        end else begin
            r = SZW'(v);
        end
        return r;
    endfunction

endpackage

### src/mqtx_rr_pick.sv
// Round-robin pick of the first non-empty queue at or after the current one.
module mqtx_rr_pick
    import mqtx_pkg::*;
(
    input  logic [NQ-1:0] busy,
    input  logic [QW-1:0] start,
    output logic          hit,
    output logic [QW-1:0] pick
);

    always_comb begin
        int unsigned idx;
        hit  = 1'b0;
        pick = start;
        // walk from the far end so the nearest busy queue wins
        for (int i = NQ - 1; i >= 0; i--) begin
            idx = 32'(start) + 32'(i);
            if (idx >= 32'(NQ)) begin
                idx = idx - 32'(NQ);
            end
            if (busy[QW'(idx)]) begin
                hit  = 1'b1;
                pick = QW'(idx);
            end
        end
    end

endmodule

### src/multi_queue_tx_buffer_round_robin_top.sv
// Top level: sixteen transmit ring queues over one shared message memory.
//
// Input channel s_valid/s_ready/s_data carries one action word: enqueue,
// dequeue, peek, find next non-empty queue, advance current queue, or count.
// Result channel m_valid/m_ready/m_data returns exactly one result word per
// action. Each action passes through two states: in the idle state the accept
// checks and updates the queue indices and issues at most one access to the
// message memory, and the lookup state picks up the registered read data and
// loads the output register. Since the memory read is registered, a new action
// is not accepted until the previous one leaves lookup. A new action is taken
// while the previous result still waits in the output register; if the
// receiver stalls longer, lookup holds until the output register frees up.
// cfg_we with cfg_wdata writes the ring size (clamped to 2..64 slots, one
// slot always left unused) and flushes every queue. Reset (aresetn low,
// synchronous) empties all queues, sets the ring size to 10 and makes the
// first queue current. The message memory itself is not cleared.
module multi_queue_tx_buffer_round_robin_top
    import mqtx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  mqtx_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output mqtx_out_t  m_data
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [SZW-1:0] ring_size_reg;
    logic [IW-1:0]  wr_idx_reg [NQ];
    logic [IW-1:0]  rd_idx_reg [NQ];
    logic [QW-1:0]  cur_q_reg;

    logic [MSG_BITS-1:0] msg_mem [NQ*SLOTS];
    logic [MSG_BITS-1:0] rd_data_reg;

    logic [1:0]    status_reg;
    logic [QW-1:0] shown_reg;
    logic [5:0]    cnt_reg;
    logic          need_msg_reg;

    logic      m_valid_reg;
    mqtx_out_t m_data_reg;

    logic          accept;
    logic          q_ok;
    logic [QW-1:0] q_addr;
    logic [QW-1:0] sel_q;
    logic [NQ-1:0] busy;
    logic          pick_hit;
    logic [QW-1:0] pick_q;

    logic [IW-1:0]  w_sel, r_sel, w_nxt, r_nxt;
    logic [SZW-1:0] w_plus, r_plus, cnt_val;
    logic           is_empty, is_full;

    logic [1:0]    step_status;
    logic [QW-1:0] step_shown;
    logic [5:0]    step_cnt;
    logic          step_need_msg;
    logic          mem_we, mem_re, wr_upd, rd_upd, cur_upd;
    logic [QW-1:0] cur_q_next;
    logic [IW-1:0] mem_idx;
    logic [AW-1:0] mem_addr;
    logic          out_load;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign q_ok = (32'(s_data.queue_type) < 32'(NUM_TYPES))
                  && (32'(s_data.queue_subtype) < 32'(NUM_SUBTYPES));
    assign q_addr = q_ok ? QW'(32'(s_data.queue_type) * 32'(NUM_SUBTYPES)
                               + 32'(s_data.queue_subtype)) : '0;

    always_comb begin
        for (int k = 0; k < NQ; k++) begin
            busy[k] = (wr_idx_reg[k] != rd_idx_reg[k]);
        end
    end

    mqtx_rr_pick u_pick (
        .busy  (busy),
        .start (cur_q_reg),
        .hit   (pick_hit),
        .pick  (pick_q)
    );

    // One index read per action: the found queue for find, else the addressed one.
    assign sel_q = (s_data.action == ACT_FIND) ? pick_q : q_addr;
    assign w_sel = wr_idx_reg[sel_q];
    assign r_sel = rd_idx_reg[sel_q];

    assign w_plus   = SZW'(w_sel) + SZW'(1);
    assign r_plus   = SZW'(r_sel) + SZW'(1);
    assign w_nxt    = (w_plus == ring_size_reg) ? '0 : IW'(w_plus);
    assign r_nxt    = (r_plus == ring_size_reg) ? '0 : IW'(r_plus);
    assign is_empty = (w_sel == r_sel);
    assign is_full  = (w_nxt == r_sel);
    assign cnt_val  = (w_sel >= r_sel) ? (SZW'(w_sel) - SZW'(r_sel))
                                       : (SZW'(w_sel) + ring_size_reg - SZW'(r_sel));

    always_comb begin
        step_status   = STS_OK;
        step_shown    = cur_q_reg;
        step_cnt      = '0;
        step_need_msg = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        wr_upd        = 1'b0;
        rd_upd        = 1'b0;
        cur_upd       = 1'b0;
        cur_q_next    = cur_q_reg;
        mem_idx       = r_sel;
        unique case (s_data.action)
            ACT_ENQUEUE: begin
                mem_idx = w_sel;
                if (!q_ok || is_full) begin
                    step_status = STS_FULL;
                end else begin
                    mem_we = accept;
                    wr_upd = accept;
                end
            end
            ACT_DEQUEUE: begin
                if (!q_ok || is_empty) begin
                    step_status = STS_EMPTY;
                end else begin
                    rd_upd = accept;
                end
            end
            ACT_PEEK: begin
                if (!q_ok || is_empty) begin
                    step_status = STS_EMPTY;
                end else begin
                    mem_re        = accept;
                    step_need_msg = 1'b1;
                end
            end
            ACT_FIND: begin
                if (pick_hit) begin
                    mem_re        = accept;
                    step_need_msg = 1'b1;
                    cur_upd       = accept;
                    cur_q_next    = pick_q;
                    step_shown    = pick_q;
                end else begin
                    step_status = STS_EMPTY;
                end
            end
            ACT_ADVANCE: begin
                cur_upd    = accept;
                cur_q_next = (32'(cur_q_reg) == 32'(NQ - 1)) ? '0 : cur_q_reg + QW'(1);
                step_shown = cur_q_next;
            end
            ACT_COUNT: begin
                if (!q_ok) begin
                    step_status = STS_EMPTY;
                end else begin
                    step_cnt = 6'(cnt_val);
                end
            end
            default: begin
                step_status = STS_OK;
            end
        endcase
    end

    assign mem_addr = AW'(32'(sel_q) * 32'(SLOTS) + 32'(mem_idx));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            msg_mem[mem_addr] <= s_data.message_in[MSG_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= msg_mem[mem_addr];
        end
    end

    // Ring size write flushes every queue.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            for (int k = 0; k < NQ; k++) begin
                wr_idx_reg[k] <= '0;
                rd_idx_reg[k] <= '0;
            end
        end else begin
            if (wr_upd) begin
                wr_idx_reg[sel_q] <= w_nxt;
            end
            if (rd_upd) begin
                rd_idx_reg[sel_q] <= r_nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= SZW'(RESET_RING_SIZE);
            cur_q_reg     <= '0;
        end else begin
            if (cfg_we) begin
                ring_size_reg <= clamp_ring_size(cfg_wdata);
            end
            if (cur_upd) begin
                cur_q_reg <= cur_q_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg   <= step_status;
            shown_reg    <= step_shown;
            cnt_reg      <= step_cnt;
            need_msg_reg <= step_need_msg;
        end
    end

    // Hold in lookup until the output register is free.
    assign out_load = (state_reg == S_LOOKUP) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status        <= status_reg;
            m_data_reg.found_type    <= queue_type_of(shown_reg);
            m_data_reg.found_subtype <= queue_subtype_of(shown_reg);
            m_data_reg.message_out   <= need_msg_reg ? 64'(rd_data_reg) : '0;
            m_data_reg.held_count    <= cnt_reg;
        end
    end

endmodule

### verif/tb.sv
// Self-checking testbench for the round-robin multi-queue transmit buffer.
`timescale 1ns / 100ps

module tb
    import mqtx_pkg::*;
();

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    mqtx_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    mqtx_out_t  m_data;

    multi_queue_tx_buffer_round_robin_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the queue state.
    logic [MSG_BITS-1:0] msg_mem [NQ*SLOTS];
    int                  wr_idx [NQ];
    int                  rd_idx [NQ];
    int                  cur_q;
    logic [6:0]          ring_sz;

    mqtx_in_t  action_q [$];
    mqtx_out_t outcome_q [$];

    int  mismatches = 0;
    int  n_actions = 0;
    int  n_results = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  n_settings = 1;
    int  stall_cycles = 0;
    int  hot_q = 0;
    bit  calm = 1'b0;

    function automatic int eff_ring_size();
        if (ring_sz < 7'd2) return 2;
        if (int'(ring_sz) > SLOTS) return SLOTS;
        return int'(ring_sz);
    endfunction

    function automatic void flush_queues();
        for (int i = 0; i < NQ; i++) begin
            wr_idx[i] = 0;
            rd_idx[i] = 0;
        end
    endfunction

    // Apply one action to the shadow state and return the word it produces.
    function automatic mqtx_out_t compute_outcome(mqtx_in_t w);
        mqtx_out_t o;
        int sz, q, wi, ri, k;
        bit hit;
        o = '0;
        sz = eff_ring_size();
        q = int'(w.queue_type) * NUM_SUBTYPES + int'(w.queue_subtype);
        wi = wr_idx[q];
        ri = rd_idx[q];
        hit = 1'b0;
        case (w.action)
            ACT_ENQUEUE: begin
                if ((wi + 1) % sz == ri) begin
                    o.status = STS_FULL;
                end else begin
                    msg_mem[q*SLOTS + wi] = w.message_in;
                    wr_idx[q] = (wi + 1) % sz;
                end
            end
            ACT_DEQUEUE: begin
                if (wi == ri) o.status = STS_EMPTY;
                else rd_idx[q] = (ri + 1) % sz;
            end
            ACT_PEEK: begin
                if (wi == ri) o.status = STS_EMPTY;
                else o.message_out = msg_mem[q*SLOTS + ri];
            end
            ACT_FIND: begin
                o.status = STS_EMPTY;
                for (int i = 0; i < NQ; i++) begin
                    k = (cur_q + i) % NQ;
                    if (!hit && wr_idx[k] != rd_idx[k]) begin
                        hit = 1'b1;
                        cur_q = k;
                        o.message_out = msg_mem[k*SLOTS + rd_idx[k]];
                        o.status = STS_OK;
                    end
                end
            end
            ACT_ADVANCE: cur_q = (cur_q + 1) % NQ;
            ACT_COUNT: o.held_count = 6'((wi + sz - ri) % sz);
            default: ;
        endcase
        o.found_type = 2'(cur_q / NUM_SUBTYPES);
        o.found_subtype = 2'(cur_q % NUM_SUBTYPES);
        return o;
    endfunction

    function automatic mqtx_in_t make_word(logic [2:0] act, int q, logic [63:0] msg);
        mqtx_in_t w;
        w.action = act;
        w.queue_type = 2'(q / NUM_SUBTYPES);
        w.queue_subtype = 2'(q % NUM_SUBTYPES);
        w.message_in = msg;
        return w;
    endfunction

    function automatic logic [63:0] rand_msg();
        return {$urandom, $urandom};
    endfunction

    // Block until every word is sent and answered.
    task automatic wait_drained();
        @(negedge aclk);
        while (action_q.size() != 0 || s_valid || outcome_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_ring_size(logic [6:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ring_sz = v;
        flush_queues();
        n_settings++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly hits one hot queue so rings fill and drain; a few spare codes mixed in.
    task automatic queue_random_actions(int n, int enq_pct);
        int r, q;
        logic [2:0] act;
        logic [63:0] msg;
        hot_q = $urandom_range(NQ - 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < enq_pct) act = ACT_ENQUEUE;
            else if (r < enq_pct + 3) act = ($urandom_range(1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
            else act = 3'($urandom_range(ACT_COUNT, ACT_DEQUEUE));
            q = ($urandom_range(99) < 70) ? hot_q : $urandom_range(NQ - 1);
            case ($urandom_range(15))
                0: msg = '0;
                1: msg = '1;
                default: msg = rand_msg();
            endcase
            action_q.push_back(make_word(act, q, msg));
        end
    endtask

    // Driver: advance to the next word once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q.push_back(compute_outcome(s_data));
                n_actions++;
            end
            if (!s_valid || s_ready) begin
                if (action_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
                    s_data <= action_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        mqtx_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing predicted: 0x%0h", m_data);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status == STS_FULL) n_full++;
                    if (want.status == STS_EMPTY) n_empty++;
                    cmp_field("status", 64'(want.status), 64'(m_data.status));
                    cmp_field("found_type", 64'(want.found_type), 64'(m_data.found_type));
                    cmp_field("found_subtype", 64'(want.found_subtype),
                              64'(m_data.found_subtype));
                    cmp_field("message_out", want.message_out, m_data.message_out);
                    cmp_field("held_count", 64'(want.held_count), 64'(m_data.held_count));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Watchdog: give up when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        ring_sz = 7'(RESET_RING_SIZE);
        cur_q = 0;
        flush_queues();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, find with no data, spare codes, wrap of the scan.
        action_q.push_back(make_word(ACT_COUNT, 0, '0));
        action_q.push_back(make_word(ACT_PEEK, 0, '0));
        action_q.push_back(make_word(ACT_DEQUEUE, 0, '0));
        action_q.push_back(make_word(ACT_FIND, 0, '1));
        action_q.push_back(make_word(ACT_ADVANCE, 0, '0));
        action_q.push_back(make_word(ACT_SPARE6, 3, '1));
        action_q.push_back(make_word(ACT_SPARE7, 12, '1));
        action_q.push_back(make_word(ACT_ENQUEUE, 5, '1));
        action_q.push_back(make_word(ACT_ENQUEUE, 5, '0));
        action_q.push_back(make_word(ACT_ENQUEUE, 15, 64'hA5A5_5A5A_0F0F_F0F0));
        action_q.push_back(make_word(ACT_FIND, 0, '0));
        action_q.push_back(make_word(ACT_PEEK, 5, '0));
        action_q.push_back(make_word(ACT_COUNT, 5, '0));
        action_q.push_back(make_word(ACT_DEQUEUE, 5, '0));
        action_q.push_back(make_word(ACT_PEEK, 5, '0));
        action_q.push_back(make_word(ACT_DEQUEUE, 5, '0));
        action_q.push_back(make_word(ACT_FIND, 0, '0));
        action_q.push_back(make_word(ACT_ENQUEUE, 3, rand_msg()));
        action_q.push_back(make_word(ACT_DEQUEUE, 15, '0));
        action_q.push_back(make_word(ACT_FIND, 0, '0));
        action_q.push_back(make_word(ACT_ADVANCE, 0, '0));
        action_q.push_back(make_word(ACT_COUNT, 3, '0));
        queue_random_actions(300, 40);

        // Leftover data is flushed by each size write.
        write_ring_size(7'd0);
        action_q.push_back(make_word(ACT_PEEK, 3, '0));
        queue_random_actions(250, 40);
        write_ring_size(7'd1);
        queue_random_actions(150, 45);

        calm = 1'b1;
        write_ring_size(7'd3);
        queue_random_actions(250, 45);
        calm = 1'b0;

        // Fill one deep ring to capacity and one past it.
        write_ring_size(7'd64);
        for (int i = 0; i < SLOTS; i++)
            action_q.push_back(make_word(ACT_ENQUEUE, 15, rand_msg()));
        action_q.push_back(make_word(ACT_COUNT, 15, '0));
        action_q.push_back(make_word(ACT_FIND, 0, '0));
        queue_random_actions(300, 55);

        write_ring_size(7'd127);
        queue_random_actions(250, 60);
        write_ring_size(7'd100);
        queue_random_actions(150, 50);
        write_ring_size(7'($urandom_range(SLOTS, 2)));
        queue_random_actions(300, 45);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("ran %0d actions over %0d ring-size settings, %0d results checked",
                 n_actions, n_settings, n_results);
        $display("predicted %0d full and %0d empty outcomes", n_full, n_empty);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
